FILE: rtl/core/circle_pair_contact_top_macros.svh
// Assertion helpers used by the checker in cpc_checker.sv.
`ifndef CIRCLE_PAIR_CONTACT_TOP_MACROS_SVH
`define CIRCLE_PAIR_CONTACT_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define CPC_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define CPC_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle that follows a reset cycle.
`define CPC_CHECK_RESET(name, cons, msg) \
    name: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cpc_pkg.sv
`timescale 1ns / 1ps

package cpc_pkg;

    localparam logic [31:0] EMPTY_CODE  = 32'hFFFF_FFFF;
    localparam int          PAIR_HALF   = 16;
    localparam logic [15:0] NORM_ONE    = 16'd16384;
    localparam int          NORM_SHIFT  = 14;
    localparam int          CDIV_STAGES = 32;
    localparam int          NDIV_STAGES = 15;
    localparam int          SQRT_STAGES = 32;

    typedef struct packed {
        logic        [31:0] pair_code;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic        [30:0] a_radius;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic        [30:0] b_radius;
    } t_in;

    typedef struct packed {
        logic        [15:0] index_a;
        logic        [15:0] index_b;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
    } t_out;

    typedef struct packed {
        logic big_x;
        logic big_y;
        logic ra_zero;
        logic coincide;
        logic neg_x;
        logic neg_y;
    } t_side;

endpackage

FILE: rtl/core/cpc_delay.sv
`timescale 1ns / 1ps

module cpc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

FILE: rtl/core/cpc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per register stage.
// The upper DBITS bits of the numerator must be below the divisor.
module cpc_div #(
    parameter int QBITS = 15,
    parameter int DBITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [QBITS+DBITS-1:0] i_num,
    input  logic [DBITS-1:0]       i_den,
    output logic [QBITS-1:0]       o_quot
);

    logic [DBITS-1:0] r_rem [QBITS];
    logic [QBITS-1:0] r_low [QBITS];
    logic [QBITS-1:0] r_quo [QBITS];
    logic [DBITS-1:0] r_den [QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        logic [DBITS-1:0] s_rem;
        logic [DBITS-1:0] s_den;
        logic [QBITS-1:0] s_low;
        logic [QBITS-1:0] s_quo;
        logic [DBITS:0]   s_trial;
        logic             s_ge;

        if (k == 0) begin : g_first
            assign s_rem = i_num[QBITS+DBITS-1:QBITS];
            assign s_low = i_num[QBITS-1:0];
            assign s_quo = '0;
            assign s_den = i_den;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_low = r_low[k-1];
            assign s_quo = r_quo[k-1];
            assign s_den = r_den[k-1];
        end

        assign s_trial = {s_rem, s_low[QBITS-1]};
        assign s_ge    = s_trial >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= s_ge ? DBITS'(s_trial - {1'b0, s_den}) : s_trial[DBITS-1:0];
                r_low[k] <= s_low << 1;
                r_quo[k] <= (s_quo << 1) | QBITS'(s_ge);
                r_den[k] <= s_den;
            end
        end
    end

    assign o_quot = r_quo[QBITS-1];

endmodule

FILE: rtl/core/cpc_sqrt.sv
`timescale 1ns / 1ps

// Floor square root of a 64-bit value, one root bit per register stage.
module cpc_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int STAGES = cpc_pkg::SQRT_STAGES;
    localparam int REM_W  = 34;

    logic [63:0]      r_rad  [STAGES];
    logic [31:0]      r_root [STAGES];
    logic [REM_W-1:0] r_rem  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [63:0]      s_rad;
        logic [31:0]      s_root;
        logic [REM_W-1:0] s_rem;
        logic [REM_W+1:0] s_cur;
        logic [REM_W+1:0] s_try;
        logic             s_ge;

        if (k == 0) begin : g_first
            assign s_rad  = i_rad;
            assign s_root = '0;
            assign s_rem  = '0;
        end else begin : g_next
            assign s_rad  = r_rad[k-1];
            assign s_root = r_root[k-1];
            assign s_rem  = r_rem[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign s_cur = {s_rem, s_rad[63:62]};
        assign s_try = {2'b00, s_root, 2'b01};
        assign s_ge  = s_cur >= s_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= s_rad << 2;
                r_root[k] <= {s_root[30:0], s_ge};
                r_rem[k]  <= s_ge ? REM_W'(s_cur - s_try) : s_cur[REM_W-1:0];
            end
        end
    end

    assign o_root = r_root[STAGES-1];

endmodule

FILE: rtl/core/cpc_front.sv
`timescale 1ns / 1ps

// Front stages: center difference, squares, overlap test, contact numerator
// and normalization of the difference vector.
module cpc_front #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  cpc_pkg::t_in          i_data,
    output logic                  o_valid,
    output cpc_pkg::t_side        o_side,
    output logic [INDEX_BITS-1:0] o_index_a,
    output logic [INDEX_BITS-1:0] o_index_b,
    output logic [31:0]           o_a_x,
    output logic [31:0]           o_a_y,
    output logic [63:0]           o_cnum_x,
    output logic [63:0]           o_cnum_y,
    output logic [31:0]           o_cden,
    output logic [63:0]           o_rad,
    output logic [30:0]           o_sm_x,
    output logic [30:0]           o_sm_y
);

    function automatic logic [4:0] f_shl(input logic [30:0] v);
        logic [4:0] res;
        res = '0;
        for (int k = 0; k < 31; k++) begin
            if (v[k]) res = 5'(30 - k);
        end
        return res;
    endfunction

    // Stage 1
    logic [32:0] n1_dx, n1_dy;
    logic r1_v, r1_empty, r1_neg_x, r1_neg_y;
    logic [INDEX_BITS-1:0] r1_ia, r1_ib;
    logic [31:0] r1_ax, r1_ay, r1_mx, r1_my, r1_rs;
    logic [30:0] r1_ra, r1_rb;

    assign n1_dx = {i_data.b_x[31], i_data.b_x} - {i_data.a_x[31], i_data.a_x};
    assign n1_dy = {i_data.b_y[31], i_data.b_y} - {i_data.a_y[31], i_data.a_y};

    // Stage 2
    logic [31:0] n2_max;
    logic r2_v, r2_empty, r2_neg_x, r2_neg_y, r2_zero, r2_shr;
    logic [4:0] r2_shl;
    logic [INDEX_BITS-1:0] r2_ia, r2_ib;
    logic [31:0] r2_ax, r2_ay, r2_mx, r2_my;
    logic [30:0] r2_ra;
    logic [63:0] r2_sx, r2_sy, r2_rsq;
    logic [62:0] r2_px, r2_py;

    assign n2_max = (r1_mx > r1_my) ? r1_mx : r1_my;

    // Stage 3
    logic [64:0] n3_dist;
    logic n3_hit;
    logic r3_v, r3_neg_x, r3_neg_y, r3_zero, r3_mxz, r3_myz, r3_ra_zero;
    logic [INDEX_BITS-1:0] r3_ia, r3_ib;
    logic [31:0] r3_ax, r3_ay;
    logic [30:0] r3_ra, r3_smx, r3_smy;
    logic [63:0] r3_cnx, r3_cny;

    assign n3_dist = {1'b0, r2_sx} + {1'b0, r2_sy};
    assign n3_hit  = !r2_empty && (n3_dist < {1'b0, r2_rsq});

    // Stage 4
    logic [31:0] n4_den;
    logic r4_v;
    cpc_pkg::t_side r4_side;
    logic [INDEX_BITS-1:0] r4_ia, r4_ib;
    logic [31:0] r4_ax, r4_ay, r4_den;
    logic [63:0] r4_cnx, r4_cny;
    logic [61:0] r4_qx, r4_qy;
    logic [30:0] r4_smx, r4_smy;

    assign n4_den = {r3_ra, 1'b0};

    // Stage 5
    logic [62:0] r5_rad;
    logic [30:0] r5_smx, r5_smy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v && n3_hit;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_empty <= i_data.pair_code == cpc_pkg::EMPTY_CODE;
            r1_ia    <= i_data.pair_code[INDEX_BITS-1:0];
            r1_ib    <= i_data.pair_code[cpc_pkg::PAIR_HALF +: INDEX_BITS];
            r1_ax    <= i_data.a_x;
            r1_ay    <= i_data.a_y;
            r1_ra    <= i_data.a_radius;
            r1_rb    <= i_data.b_radius;
            r1_neg_x <= n1_dx[32];
            r1_neg_y <= n1_dy[32];
            r1_mx    <= n1_dx[32] ? 32'(33'd0 - n1_dx) : n1_dx[31:0];
            r1_my    <= n1_dy[32] ? 32'(33'd0 - n1_dy) : n1_dy[31:0];
            r1_rs    <= {1'b0, i_data.a_radius} + {1'b0, i_data.b_radius};

            r2_empty <= r1_empty;
            r2_ia    <= r1_ia;
            r2_ib    <= r1_ib;
            r2_ax    <= r1_ax;
            r2_ay    <= r1_ay;
            r2_ra    <= r1_ra;
            r2_neg_x <= r1_neg_x;
            r2_neg_y <= r1_neg_y;
            r2_mx    <= r1_mx;
            r2_my    <= r1_my;
            r2_zero  <= (r1_mx == '0) && (r1_my == '0);
            r2_sx    <= r1_mx * r1_mx;
            r2_sy    <= r1_my * r1_my;
            r2_rsq   <= r1_rs * r1_rs;
            r2_px    <= r1_mx * r1_rb;
            r2_py    <= r1_my * r1_rb;
            r2_shr   <= n2_max[31];
            r2_shl   <= f_shl(n2_max[30:0]);

            r3_ia      <= r2_ia;
            r3_ib      <= r2_ib;
            r3_ax      <= r2_ax;
            r3_ay      <= r2_ay;
            r3_ra      <= r2_ra;
            r3_ra_zero <= r2_ra == '0;
            r3_neg_x   <= r2_neg_x;
            r3_neg_y   <= r2_neg_y;
            r3_zero    <= r2_zero;
            r3_mxz     <= r2_mx == '0;
            r3_myz     <= r2_my == '0;
            r3_cnx     <= {1'b0, r2_px} + {33'd0, r2_ra};
            r3_cny     <= {1'b0, r2_py} + {33'd0, r2_ra};
            // Scale both components so that the larger one has exactly 31 bits.
            r3_smx     <= r2_shr ? r2_mx[31:1] : 31'(r2_mx << r2_shl);
            r3_smy     <= r2_shr ? r2_my[31:1] : 31'(r2_my << r2_shl);

            // A quotient of 2^32 or more saturates whatever the center.
            r4_side.big_x    <= r3_ra_zero ? !r3_mxz : (r3_cnx[63:32] >= n4_den);
            r4_side.big_y    <= r3_ra_zero ? !r3_myz : (r3_cny[63:32] >= n4_den);
            r4_side.ra_zero  <= r3_ra_zero;
            r4_side.coincide <= r3_zero;
            r4_side.neg_x    <= r3_neg_x;
            r4_side.neg_y    <= r3_neg_y;
            r4_ia  <= r3_ia;
            r4_ib  <= r3_ib;
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_den <= n4_den;
            r4_cnx <= r3_cnx;
            r4_cny <= r3_cny;
            r4_qx  <= r3_smx * r3_smx;
            r4_qy  <= r3_smy * r3_smy;
            r4_smx <= r3_smx;
            r4_smy <= r3_smy;

            r5_rad <= {1'b0, r4_qx} + {1'b0, r4_qy};
            r5_smx <= r4_smx;
            r5_smy <= r4_smy;
        end
    end

    assign o_valid   = r4_v;
    assign o_side    = r4_side;
    assign o_index_a = r4_ia;
    assign o_index_b = r4_ib;
    assign o_a_x     = r4_ax;
    assign o_a_y     = r4_ay;
    assign o_cnum_x  = r4_cnx;
    assign o_cnum_y  = r4_cny;
    assign o_cden    = r4_den;
    assign o_rad     = {1'b0, r5_rad};
    assign o_sm_x    = r5_smx;
    assign o_sm_y    = r5_smy;

endmodule

FILE: rtl/core/circle_pair_contact_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data (cpc_pkg::t_in)
// result    out        o_valid / i_stall  o_data (cpc_pkg::t_out)
//
// One pair enters per clock while o_stall is low.
// Latency is set by the 32-stage square root and the 15-stage normal divider.
// Synchronous active-low reset clears the valid bits; payload is not reset.
// A stalled result is held and one more goes to a skid register; then o_stall
// rises and the whole pipeline freezes until the output moves again.
module circle_pair_contact_top #(
    parameter int INDEX_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cpc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output cpc_pkg::t_out o_data
);

    localparam int SIDE_W     = $bits(cpc_pkg::t_side) + 2 * INDEX_BITS + 64;
    localparam int SIDE_DEPTH = cpc_pkg::SQRT_STAGES + cpc_pkg::NDIV_STAGES + 2;
    localparam int QDLY_DEPTH = SIDE_DEPTH - cpc_pkg::CDIV_STAGES;
    localparam int NNUM_W     = cpc_pkg::NDIV_STAGES + 32;
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    function automatic logic [31:0] f_contact(input logic [31:0] a, input logic [31:0] q,
                                              input logic neg, input logic big);
        logic [33:0] s;
        logic [31:0] res;
        s = neg ? ({{2{a[31]}}, a} - {2'b00, q}) : ({{2{a[31]}}, a} + {2'b00, q});
        priority if (big) res = neg ? SAT_MIN : SAT_MAX;
        else if (!s[33] && (s[32] || s[31])) res = SAT_MAX;
        else if (s[33] && !(s[32] && s[31])) res = SAT_MIN;
        else res = s[31:0];
        return res;
    endfunction

    function automatic logic [15:0] f_norm(input logic [14:0] q, input logic neg,
                                           input logic zero);
        logic [15:0] n;
        n = ({1'b0, q} > cpc_pkg::NORM_ONE) ? cpc_pkg::NORM_ONE : {1'b0, q};
        priority if (zero) n = '0;
        else if (neg) n = 16'd0 - n;
        else n = n;
        return n;
    endfunction

    logic en;

    logic                  f_valid;
    cpc_pkg::t_side        f_side;
    logic [INDEX_BITS-1:0] f_ia, f_ib;
    logic [31:0]           f_ax, f_ay, f_cden;
    logic [63:0]           f_cnum_x, f_cnum_y, f_rad;
    logic [30:0]           f_smx, f_smy;

    logic [31:0]           cq_x, cq_y, cqd_x, cqd_y, w_len;
    logic [30:0]           w_smx, w_smy;
    logic [NNUM_W-1:0]     r_nnum_x, r_nnum_y;
    logic [31:0]           r_nlen;
    logic [14:0]           nq_x, nq_y;

    logic                  p_valid;
    logic [SIDE_W-1:0]     p_bus;
    cpc_pkg::t_side        p_side;
    logic [INDEX_BITS-1:0] p_ia, p_ib;
    logic [31:0]           p_ax, p_ay;
    cpc_pkg::t_out         p_data;

    logic                  r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;
    cpc_pkg::t_out         r_out, r_skid, n_out, n_skid;

    assign en = !r_skid_valid;

    cpc_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_valid   (f_valid),
        .o_side    (f_side),
        .o_index_a (f_ia),
        .o_index_b (f_ib),
        .o_a_x     (f_ax),
        .o_a_y     (f_ay),
        .o_cnum_x  (f_cnum_x),
        .o_cnum_y  (f_cnum_y),
        .o_cden    (f_cden),
        .o_rad     (f_rad),
        .o_sm_x    (f_smx),
        .o_sm_y    (f_smy)
    );

    // Contact offset quotients.
    cpc_div #(.QBITS(cpc_pkg::CDIV_STAGES), .DBITS(32)) u_cdiv_x (
        .i_clk(i_clk), .i_en(en), .i_num(f_cnum_x), .i_den(f_cden), .o_quot(cq_x)
    );
    cpc_div #(.QBITS(cpc_pkg::CDIV_STAGES), .DBITS(32)) u_cdiv_y (
        .i_clk(i_clk), .i_en(en), .i_num(f_cnum_y), .i_den(f_cden), .o_quot(cq_y)
    );
    cpc_delay #(.WIDTH(64), .DEPTH(QDLY_DEPTH)) u_cq_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(1'b0),
        .i_data({cq_x, cq_y}), .o_valid(), .o_data({cqd_x, cqd_y})
    );

    // Length of the scaled difference vector.
    cpc_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_rad(f_rad), .o_root(w_len)
    );
    cpc_delay #(.WIDTH(62), .DEPTH(cpc_pkg::SQRT_STAGES)) u_sm_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(1'b0),
        .i_data({f_smx, f_smy}), .o_valid(), .o_data({w_smx, w_smy})
    );

    // Rounded normal numerators: m * 2^14 + L / 2.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nnum_x <= NNUM_W'({w_smx, {cpc_pkg::NORM_SHIFT{1'b0}}}) + NNUM_W'(w_len[31:1]);
            r_nnum_y <= NNUM_W'({w_smy, {cpc_pkg::NORM_SHIFT{1'b0}}}) + NNUM_W'(w_len[31:1]);
            r_nlen   <= w_len;
        end
    end

    cpc_div #(.QBITS(cpc_pkg::NDIV_STAGES), .DBITS(32)) u_ndiv_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_nnum_x), .i_den(r_nlen), .o_quot(nq_x)
    );
    cpc_div #(.QBITS(cpc_pkg::NDIV_STAGES), .DBITS(32)) u_ndiv_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_nnum_y), .i_den(r_nlen), .o_quot(nq_y)
    );

    cpc_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_DEPTH)) u_side_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_data  ({f_side, f_ia, f_ib, f_ax, f_ay}),
        .o_valid (p_valid),
        .o_data  (p_bus)
    );

    assign {p_side, p_ia, p_ib, p_ax, p_ay} = p_bus;

    always_comb begin
        p_data.index_a   = 16'(p_ia);
        p_data.index_b   = 16'(p_ib);
        p_data.contact_x = f_contact(p_ax, p_side.ra_zero ? 32'd0 : cqd_x,
                                     p_side.neg_x, p_side.big_x);
        p_data.contact_y = f_contact(p_ay, p_side.ra_zero ? 32'd0 : cqd_y,
                                     p_side.neg_y, p_side.big_y);
        p_data.normal_x  = f_norm(nq_x, p_side.neg_x, p_side.coincide);
        p_data.normal_y  = f_norm(nq_y, p_side.neg_y, p_side.coincide);
    end

    // Output register with one skid entry behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        priority if (r_out_valid && !i_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (en && p_valid) begin
                n_out = p_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (!r_out_valid) begin
            if (en && p_valid) begin
                n_out       = p_data;
                n_out_valid = 1'b1;
            end
        end else begin
            if (en && p_valid) begin
                n_skid       = p_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_stall = r_skid_valid;

endmodule

FILE: rtl/core/cpc_checker.sv
`timescale 1ns / 1ps
`include "circle_pair_contact_top_macros.svh"

module cpc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input cpc_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input cpc_pkg::t_out o_data
);

    logic norm_x_ok;

    assign norm_x_ok = (o_data.normal_x <= 16'sd16384) && (o_data.normal_x >= -16'sd16384);

    `CPC_CHECK_NEXT(a_hold_valid, o_valid && i_stall, o_valid, "result dropped while stalled")
    `CPC_CHECK_NEXT(a_hold_data, o_valid && i_stall, $stable(o_data), "stalled result changed")
    `CPC_CHECK(a_norm_x, o_valid, norm_x_ok, "normal x out of range")
    `CPC_CHECK_RESET(a_reset, !o_valid && !o_stall, "valid or stall set after reset")

endmodule

bind circle_pair_contact_top cpc_checker u_cpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

FILE: dv/circle_pair_contact_checker.sv
`timescale 1ns / 1ps

module circle_pair_contact_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall_in,
    input  cpc_pkg::t_in  i_data,
    input  logic          i_out_valid,
    input  logic          i_stall_out,
    input  cpc_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    cpc_pkg::t_out contact_queue[$];

    function automatic longint signed clamp32(longint signed v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] contact_axis(longint signed a, longint signed d,
                                                 longint unsigned ra, longint unsigned rb);
        longint unsigned m;
        longint unsigned q;
        m = (d < 0) ? longint'(-d) : longint'(d);
        if (ra == 0) q = (m == 0) ? 0 : (64'd1 << 62);
        else q = (m * rb + ra) / (ra * 2);
        return 32'(clamp32((d < 0) ? a - longint'(q) : a + longint'(q)));
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] unit_comp(longint unsigned m, logic neg,
                                              longint unsigned len);
        longint unsigned n;
        n = (m * cpc_pkg::NORM_ONE + len / 2) / len;
        if (n > cpc_pkg::NORM_ONE) n = cpc_pkg::NORM_ONE;
        return neg ? 16'(-n) : 16'(n);
    endfunction

    // Returns 1 when the pair overlaps and fills in the expected contact.
    function automatic bit predict_contact(cpc_pkg::t_in p, output cpc_pkg::t_out r);
        longint signed ax, ay, bx, by, dx, dy;
        longint unsigned ra, rb, mx, my, sx, sy, dsq, rsq, len;
        int blen;
        r = '0;
        if (p.pair_code == cpc_pkg::EMPTY_CODE) return 0;
        ax = p.a_x; ay = p.a_y; bx = p.b_x; by = p.b_y;
        ra = p.a_radius; rb = p.b_radius;
        dx = bx - ax; dy = by - ay;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        sx = mx * mx; sy = my * my;
        dsq = sx + sy;
        rsq = (ra + rb) * (ra + rb);
        if (dsq < sx || dsq >= rsq) return 0;
        r.index_a = p.pair_code[15:0];
        r.index_b = p.pair_code[31:16];
        r.contact_x = contact_axis(ax, dx, ra, rb);
        r.contact_y = contact_axis(ay, dy, ra, rb);
        if (mx != 0 || my != 0) begin
            len = (mx > my) ? mx : my;
            blen = 0;
            while (len != 0) begin
                blen++;
                len >>= 1;
            end
            if (blen > 31) begin
                mx >>= (blen - 31);
                my >>= (blen - 31);
            end else if (blen < 31) begin
                mx <<= (31 - blen);
                my <<= (31 - blen);
            end
            len = floor_sqrt(mx * mx + my * my);
            r.normal_x = unit_comp(mx, dx < 0, len);
            r.normal_y = unit_comp(my, dy < 0, len);
        end
        return 1;
    endfunction

    assign o_pending = contact_queue.size();

    always @(posedge i_clk) begin
        cpc_pkg::t_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_stall_in && predict_contact(i_data, want))
                contact_queue = {contact_queue, want};
            if (i_out_valid && !i_stall_out) begin
                if (contact_queue.size() == 0) begin
                    $error("unexpected result transfer %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = contact_queue.pop_front();
                    if (want != i_out_data) begin
                        o_fail_count <= o_fail_count + 1;
                        if (want.index_a != i_out_data.index_a)
                            $error("index_a exp %0d got %0d", want.index_a, i_out_data.index_a);
                        if (want.index_b != i_out_data.index_b)
                            $error("index_b exp %0d got %0d", want.index_b, i_out_data.index_b);
                        if (want.contact_x != i_out_data.contact_x)
                            $error("contact_x exp %0d got %0d", want.contact_x,
                                   i_out_data.contact_x);
                        if (want.contact_y != i_out_data.contact_y)
                            $error("contact_y exp %0d got %0d", want.contact_y,
                                   i_out_data.contact_y);
                        if (want.normal_x != i_out_data.normal_x)
                            $error("normal_x exp %0d got %0d", want.normal_x,
                                   i_out_data.normal_x);
                        if (want.normal_y != i_out_data.normal_y)
                            $error("normal_y exp %0d got %0d", want.normal_y,
                                   i_out_data.normal_y);
                    end
                end
            end
        end
    end
endmodule

FILE: dv/circle_pair_contact_top_test.sv
`timescale 1ns / 1ps

module circle_pair_contact_top_test;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          in_valid = 0;
    logic          in_stall;
    cpc_pkg::t_in  in_data = '0;
    logic          out_valid;
    logic          out_stall = 0;
    cpc_pkg::t_out out_data;
    int            fail_count;
    int            pending;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_off = 0;
    bit            hold_req = 0;

    always #1 i_clk = ~i_clk;

    circle_pair_contact_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    circle_pair_contact_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_data(in_data),
        .i_out_valid(out_valid), .i_stall_out(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stall, with a long hold-off stretch on request.
    always @(negedge i_clk) begin
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Once requested, the receiver holds off for a single long stretch.
    initial begin
        int held;
        wait (hold_req);
        hold_off = 1;
        for (held = 0; held < 300; held++) @(negedge i_clk);
        hold_off = 0;
    end

    function automatic logic [31:0] rand_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return 32'($signed($urandom_range(4000000)) - 2000000);
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    function automatic cpc_pkg::t_in random_pair();
        cpc_pkg::t_in p;
        int shape;
        shape = $urandom_range(9);
        p.pair_code = ($urandom_range(19) == 0) ? cpc_pkg::EMPTY_CODE : $urandom();
        if (shape == 0) begin
            p.a_x = $urandom(); p.a_y = $urandom();
            p.b_x = $urandom(); p.b_y = $urandom();
            p.a_radius = 31'($urandom()); p.b_radius = 31'($urandom());
        end else begin
            // Mostly nearby circles so that a good share of pairs overlap.
            p.a_x = rand_coord(shape % 3);
            p.a_y = rand_coord(shape % 3);
            p.b_x = p.a_x + 32'($signed($urandom_range(400000)) - 200000);
            p.b_y = p.a_y + 32'($signed($urandom_range(400000)) - 200000);
            p.a_radius = 31'($urandom_range(200000, 1));
            p.b_radius = 31'($urandom_range(200000, 1));
        end
        if (p.a_radius == 0) p.a_radius = 1;
        if (p.b_radius == 0) p.b_radius = 1;
        return p;
    endfunction

    task automatic send_pair(cpc_pkg::t_in p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        in_valid <= 1;
        in_data <= p;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_pair_seq(cpc_pkg::t_in p);
        send_pair(p);
    endtask

    function automatic cpc_pkg::t_in make_pair(logic [31:0] code, logic [31:0] ax,
                                               logic [31:0] ay, logic [30:0] ra,
                                               logic [31:0] bx, logic [31:0] by,
                                               logic [30:0] rb);
        cpc_pkg::t_in p;
        p.pair_code = code; p.a_x = ax; p.a_y = ay; p.a_radius = ra;
        p.b_x = bx; p.b_y = by; p.b_radius = rb;
        return p;
    endfunction

    initial begin
        #2000000;
        $display("circle_pair_contact_top_test failed");
        $finish;
    end

    initial begin
        cpc_pkg::t_in directed[$];
        int           waited;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        directed = {directed, make_pair(32'h0002_0001, 0, 0, 31'h10000, 32'h8000, 0,
                                        31'h10000)};
        directed = {directed, make_pair(cpc_pkg::EMPTY_CODE, 0, 0, 31'h10000, 0, 0,
                                        31'h10000)};
        directed = {directed, make_pair(32'hFFFF_FFFE, 5, 7, 3, 5, 7, 4)};
        directed = {directed, make_pair(32'h0000_FFFF, 0, 0, 1, 2, 0, 1)};
        directed = {directed, make_pair(32'hFFFF_0000, 0, 0, 2, 3, 0, 2)};
        directed = {directed, make_pair(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                        32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF)};
        directed = {directed, make_pair(1, 32'h8000_0000, 32'h8000_0000, 1,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF)};
        directed = {directed, make_pair(2, 32'h7FFF_0000, 0, 1, 32'h7FFF_FFFF, 0,
                                        31'h7FFF_FFFF)};
        directed = {directed, make_pair(3, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000, 0, 1)};
        directed = {directed, make_pair(4, 100, 200, 50, 100 - 60, 200 + 80, 60)};
        directed = {directed, make_pair(5, 0, 0, 1, 1, 1, 1)};
        directed = {directed, make_pair(6, -1000, 1000, 31'h7FFF_FFFF, -1000, -1000,
                                        31'h7FFF_FFFF)};
        directed = {directed, make_pair(7, 0, 0, 3, 0, 10, 7)};
        directed = {directed, make_pair(8, 0, 0, 3, 6, 8, 7)};
        directed = {directed, make_pair(9, 0, 0, 1, 1, 0, 1)};
        foreach (directed[i]) send_pair(directed[i]);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 55 : 38) : 0;
            recv_stall_pct = (phase == 2) ? 55 : ((phase == 3) ? 38 : 0);
            if (phase == 0) hold_req = 1;
            for (int n = 0; n < 460; n++) begin
                send_pair_seq(random_pair());
            end
        end
        in_valid <= 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (100) @(negedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("circle_pair_contact_top_test passed");
        else
            $display("circle_pair_contact_top_test failed");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cpc_pkg.sv
rtl/core/cpc_delay.sv
rtl/core/cpc_div.sv
rtl/core/cpc_sqrt.sv
rtl/core/cpc_front.sv
rtl/core/circle_pair_contact_top.sv
rtl/core/cpc_checker.sv
dv/circle_pair_contact_checker.sv
dv/circle_pair_contact_top_test.sv
